@@ hdl/zttso_pkg.sv @@
// ----------------------------------------------------------------------------
// zttso_pkg
// Shared types and constants for the zone time to sample offset block.
// ----------------------------------------------------------------------------
package zttso_pkg;

   localparam int CMD_W     = 2;
   localparam int VALUE_W   = 32;
   localparam int SPP_W     = 16;
   localparam int ZCOUNT_W  = 7;
   localparam int ZIDX_W    = 6;
   localparam int OFFSET_W  = 42;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = VALUE_W + SPP_W;
   localparam int DIVCNT_W  = 5;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [CMD_W-1:0] CMD_ZONE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PACKET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic REG_SPP    = 1'b0;
   localparam logic REG_ZCOUNT = 1'b1;

   localparam logic [SPP_W-1:0]    SPP_RESET    = 16'd1;
   localparam logic [ZCOUNT_W-1:0] ZCOUNT_RESET = 7'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ZADDR,
      ST_ZTIME,
      ST_PADDR,
      ST_PCMP,
      ST_CHECK,
      ST_MUL2,
      ST_DIV,
      ST_SUM,
      ST_EMIT
   } state_type;

endpackage

@@ hdl/zone_time_to_sample_offset.sv @@
// ----------------------------------------------------------------------------
// zone_time_to_sample_offset
// Maps zone times onto loaded packet timestamps, giving sample offsets.
// ----------------------------------------------------------------------------
// Load words (zone offset, packet timestamp) are taken one per cycle. A
// compute word runs a sequencer that walks the packet store with a forward
// pointer, then uses one 32x16 multiplier and a radix-2 divider per in-range
// zone; an out-of-range zone skips them. Each result can be held by an
// output stall. The block takes no word until the last result of a compute
// has been taken. Stores are not cleared by reset.
module zone_time_to_sample_offset #(
   parameter int MAX_ZONES   = 64,
   parameter int MAX_PACKETS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [zttso_pkg::VALUE_W-1:0]  req_tdata,   // value
   input  logic [zttso_pkg::CMD_W-1:0]    req_tuser,   // command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,   // zone_index, sample_offset
   output logic                           rsp_tuser,   // out_of_range
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [zttso_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [zttso_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [zttso_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import zttso_pkg::*;

   localparam int ZW  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int ZCW = $clog2(MAX_ZONES + 1);
   localparam int PW  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int PCW = $clog2(MAX_PACKETS + 1);

   logic [VALUE_W-1:0] zo_mem [MAX_ZONES];
   logic [VALUE_W-1:0] pt_mem [MAX_PACKETS];
   logic [VALUE_W-1:0] zo_rd_ff, pt_rd_ff;

   state_type state_ff, state_in;
   logic [SPP_W-1:0]    spp_ff;
   logic [ZCOUNT_W-1:0] zcount_ff;
   logic [ZCW-1:0]      zcnt_ff;
   logic [PCW-1:0]      pcnt_ff;
   logic [ZCW-1:0]      n_ff, n_in;
   logic [ZW-1:0]       i_ff, i_in;
   logic [PCW-1:0]      k_ff, k_in;
   logic [VALUE_W-1:0]  start_ff, start_in;
   logic [VALUE_W-1:0]  base_ff, base_in;
   logic [VALUE_W-1:0]  zt_ff, zt_in;
   logic [VALUE_W-1:0]  prev_ff, prev_in;
   logic [VALUE_W-1:0]  cur_ff, cur_in;
   logic [VALUE_W-1:0]  den_ff, den_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   prod2_ff, prod2_in;
   logic [VALUE_W:0]    rem_ff, rem_in;
   logic [VALUE_W-1:0]  dq_ff, dq_in;
   logic [DIVCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic                oor_ff, oor_in;

   logic                  accept, csr_wr;
   logic [VALUE_W-1:0]    mul_a;
   logic [PROD_W-1:0]     mul_p;
   logic [VALUE_W:0]      rem_sh;
   logic [PROD_W:0]       sum;
   logic [ZCW-1:0]        n_cap;
   logic [VALUE_W-1:0]    zt_base;
   logic                  in_range;

   assign accept     = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ZCOUNT) ? CSR_DW'(zcount_ff) : CSR_DW'(spp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff    <= SPP_RESET;
         zcount_ff <= ZCOUNT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_SPP) begin
            spp_ff <= csr_pwdata[SPP_W-1:0];
         end else begin
            zcount_ff <= csr_pwdata[ZCOUNT_W-1:0];
         end
      end
   end

   // store fill
   always_ff @(posedge clock) begin
      if (reset) begin
         zcnt_ff <= '0;
         pcnt_ff <= '0;
      end else if (accept) begin
         if (req_tuser == CMD_ZONE && zcnt_ff < ZCW'(MAX_ZONES)) begin
            zcnt_ff <= zcnt_ff + 1'b1;
         end
         if (req_tuser == CMD_PACKET && pcnt_ff < PCW'(MAX_PACKETS)) begin
            pcnt_ff <= pcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_ZONE && zcnt_ff < ZCW'(MAX_ZONES)) begin
         zo_mem[zcnt_ff[ZW-1:0]] <= req_tdata;
      end
      zo_rd_ff <= zo_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == CMD_PACKET && pcnt_ff < PCW'(MAX_PACKETS)) begin
         pt_mem[pcnt_ff[PW-1:0]] <= req_tdata;
      end
      pt_rd_ff <= pt_mem[k_ff[PW-1:0]];
   end

   assign mul_a   = (state_ff == ST_MUL2) ? VALUE_W'(k_ff - 1'b1) : (zt_ff - prev_ff);
   assign mul_p   = PROD_W'(mul_a) * PROD_W'(spp_ff);
   assign rem_sh  = {rem_ff[VALUE_W-1:0], dq_ff[VALUE_W-1]};
   assign sum     = (PROD_W+1)'({prod2_ff[PROD_W-FRAC_W-1:0], {FRAC_W{1'b0}}})
                    + (PROD_W+1)'(dq_ff);
   assign n_cap   = (zcount_ff > ZCOUNT_W'(MAX_ZONES)) ? ZCW'(MAX_ZONES) : ZCW'(zcount_ff);
   assign zt_base = (i_ff == '0) ? zo_rd_ff : base_ff;
   assign in_range = (k_ff != '0) && (k_ff < pcnt_ff) && (zt_ff >= prev_ff)
                     && (cur_ff != prev_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
      end
      n_ff     <= n_in;
      start_ff <= start_in;
      base_ff  <= base_in;
      zt_ff    <= zt_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      den_ff   <= den_in;
      prod_ff  <= prod_in;
      prod2_ff <= prod2_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      dcnt_ff  <= dcnt_in;
      off_ff   <= off_in;
      oor_ff   <= oor_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      start_in = start_ff;
      base_in  = base_ff;
      zt_in    = zt_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      prod2_in = prod2_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      dcnt_in  = dcnt_ff;
      off_in   = off_ff;
      oor_in   = oor_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tuser == CMD_COMPUTE && n_cap != '0) begin
               n_in     = n_cap;
               start_in = req_tdata;
               i_in     = '0;
               k_in     = '0;
               state_in = ST_ZADDR;
            end
         end
         ST_ZADDR: state_in = ST_ZTIME;
         ST_ZTIME: begin
            base_in  = zt_base;
            zt_in    = start_ff + zo_rd_ff - zt_base;
            state_in = ST_PADDR;
         end
         ST_PADDR: begin
            state_in = (k_ff < pcnt_ff) ? ST_PCMP : ST_CHECK;
         end
         ST_PCMP: begin
            if (pt_rd_ff <= zt_ff) begin
               prev_in  = pt_rd_ff;
               k_in     = k_ff + 1'b1;
               state_in = ST_PADDR;
            end else begin
               cur_in   = pt_rd_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (in_range) begin
               prod_in  = mul_p;
               den_in   = cur_ff - prev_ff;
               state_in = ST_MUL2;
            end else begin
               off_in   = '0;
               oor_in   = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_MUL2: begin
            prod2_in = mul_p;
            rem_in   = {1'b0, prod_ff[PROD_W-1:FRAC_W]};
            dq_in    = {prod_ff[FRAC_W-1:0], {FRAC_W{1'b0}}};
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               dq_in  = {dq_ff[VALUE_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               dq_in  = {dq_ff[VALUE_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == '1) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            off_in   = (sum[PROD_W:OFFSET_W] != '0) ? '1 : sum[OFFSET_W-1:0];
            oor_in   = 1'b0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (ZCW'(i_ff) + 1'b1 == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_ZADDR;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {off_ff, ZIDX_W'(i_ff)};
   assign rsp_tuser = oor_ff;
   assign rsp_tlast = (ZCW'(i_ff) + 1'b1 == n_ff);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while result pending");
   a_busy_after_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("compute ended before last zone");
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= pcnt_ff)
      else $error("packet pointer past loaded timestamps");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> off_ff == '0)
      else $error("out of range result with nonzero offset");

endmodule
